// ===== sv/bbx_pkg.sv =====
// Shared types, register codes and constants for the 3x3 boundary extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package bbx_pkg;

  // Widths fixed by the register map and the stream payload.
  localparam int SIZE_W    = 11;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Number of stored window columns; the third column is the one arriving.
  localparam int WIN_CELLS = 2;

  // Register reset values and size limits.
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);

  // Values written into a thinned pixel: FILL_PIXEL in background mode, CLEAR_PIXEL in foreground mode.
  localparam logic [PIX_W-1:0] FILL_PIXEL  = 8'hFF;
  localparam logic [PIX_W-1:0] CLEAR_PIXEL = 8'h00;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONNECTIVITY = 2'd0,
    CFG_GROUND       = 2'd1,
    CFG_WIDTH        = 2'd2,
    CFG_HEIGHT       = 2'd3
  } cfg_index_t;

  // One window column: flag of the upper row, pixel of the middle row,
  // flag of the lower row.
  typedef struct packed {
    logic             up;
    logic [PIX_W-1:0] mid;
    logic             low;
  } col_t;

  // One line store word: flag of the row two above, pixel of the row above.
  typedef struct packed {
    logic             flag;
    logic [PIX_W-1:0] pixel;
  } line_word_t;

  // A pixel counts as foreground when it is nonzero.
  function automatic logic is_fg(input logic [PIX_W-1:0] p);
    return p != '0;
  endfunction

endpackage

`default_nettype wire

// ===== sv/binary_boundary_3x3_core.sv =====
// Top level of the streaming 3x3 binary boundary extractor.
// Depends on bbx_pkg, bbx_line and bbx_cell.
//
// The block takes one beat per clock and sustains one pixel per cycle while
// the output is not stalled: each beat needs a single read and a single
// write of the column line store, and the two window cells shift once per
// beat. An accepted beat is registered in the read stage, and its result is
// written into the output register when that stage advances. In image terms
// each output pixel lags its input by one row plus one pixel, so after the
// last pixel of a frame the source sends frame_width + 1 flush beats (tuser
// high, or any pixel beat) to drain it. A flush beat sent before the frame's
// last pixel is dropped. Writing frame_width or frame_height restarts the
// frame; mode writes apply to the next output. The line store needs no
// clearing after reset, so the block is ready at once.
`default_nettype none

module binary_boundary_3x3_core
  import bbx_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  // Input stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  input  wire logic                 s_axis_tuser,   // [0] cmd: 1 flush tick
  // Output stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [PIX_W-1:0]          m_axis_tdata,   // [7:0] out_pixel
  output logic                      m_axis_tlast    // frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int CW    = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
  localparam int RW    = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;

  // Clamp a size register write into [3, maxv].
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

  // Configuration registers.
  logic              connectivity;
  logic              ground;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              cfg_acc;
  logic              restart;

  // Input position.
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col_x;
  logic [CW-1:0]    fw_x;
  logic [RW-1:0]    row_x;
  logic [RW-1:0]    fh_x;

  // Per-beat decisions at the input.
  logic in_acc;
  logic draining;
  logic skip;
  logic emit_now;
  logic interior_now;
  logic fend_now;
  logic s1_load;

  // Line store read stage.
  logic              s1_valid;
  logic              s1_emit;
  logic              s1_interior;
  logic              s1_fend;
  logic [PIX_W-1:0]  s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic              s1_adv;
  logic              out_free;
  line_word_t        rd_word;
  line_word_t        wr_word;

  // Window.
  col_t chain [WIN_CELLS+1];
  logic win_clear;

  // Result logic.
  logic             need;
  logic             hit;
  logic [PIX_W-1:0] center;
  logic [PIX_W-1:0] result;

  // Configuration port is always ready.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc && (cfg_index_t'(cfg_index) == CFG_WIDTH ||
                                 cfg_index_t'(cfg_index) == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      connectivity <= 1'b0;
      ground       <= 1'b0;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CONNECTIVITY: connectivity <= cfg_data[0];
        CFG_GROUND:       ground       <= cfg_data[0];
        CFG_WIDTH:        frame_width  <= clamp_size(cfg_data, MAX_WIDTH);
        CFG_HEIGHT:       frame_height <= clamp_size(cfg_data, MAX_HEIGHT);
      endcase
    end
  end

  // Position compares in a common width.
  assign col_x = CW'(col);
  assign fw_x  = CW'(frame_width);
  assign row_x = RW'(row);
  assign fh_x  = RW'(frame_height);

  // Classify the incoming beat. The last output of a frame comes out with
  // the first column of the second row past the frame.
  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign draining     = row_x >= fh_x;
  assign skip         = s_axis_tuser && !draining;
  assign emit_now     = (row_x >= RW'(2)) || (row_x == RW'(1) && col_x >= CW'(1));
  assign interior_now = (col_x >= CW'(2)) && (row_x >= RW'(2)) && !draining;
  assign fend_now     = (row_x == fh_x + RW'(1)) && (col == '0);
  assign s1_load      = in_acc && !skip;

  // The read stage moves on when its result has a place to go.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (s1_load) begin
      if (fend_now) begin
        col <= '0;
        row <= '0;
      end else if (col_x + CW'(1) >= fw_x) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload; a draining beat carries a zero pixel.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_emit     <= emit_now;
      s1_interior <= interior_now;
      s1_fend     <= fend_now;
      s1_pix      <= draining ? '0 : s_axis_tdata;
      s1_col      <= col;
    end
  end

  // Column line store: read as a beat enters, written back as it leaves.
  assign wr_word.flag  = is_fg(rd_word.pixel);
  assign wr_word.pixel = s1_pix;

  bbx_line #(
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .rd_en   (s1_load),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // Newest window column, then the chain of stored columns.
  assign chain[0].up  = rd_word.flag;
  assign chain[0].mid = rd_word.pixel;
  assign chain[0].low = is_fg(s1_pix);
  assign win_clear    = restart || (s1_adv && s1_fend);

  for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
    bbx_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_adv),
      .clear  (win_clear),
      .col_in (chain[i]),
      .col    (chain[i+1])
    );
  end

  // Neighborhood test on the window with the newest column on the right.
  always_comb begin
    need   = !ground;
    center = chain[1].mid;
    hit    = (is_fg(center) == need) && (chain[1].up == need) &&
             (chain[1].low == need) && (is_fg(chain[2].mid) == need) &&
             (is_fg(chain[0].mid) == need);
    if (connectivity) begin
      hit = hit && (chain[0].up == need) && (chain[2].up == need) &&
            (chain[0].low == need) && (chain[2].low == need);
    end
    result = center;
    if (s1_interior && hit) begin
      result = ground ? FILL_PIXEL : CLEAR_PIXEL;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_axis_tdata <= result;
      m_axis_tlast <= s1_fend;
    end
  end

  // The column never reaches the frame width.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_x < fw_x)
    else $error("column counter past frame width");

  // The row never goes past the second flush row.
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_x <= fh_x + RW'(1))
    else $error("row counter past drain rows");

  // The beat that ends a frame restarts the position counters.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    s1_load && fend_now |=> (col == '0) && (row == '0))
    else $error("frame end did not restart position");

  // A result waiting on a full output keeps the read stage occupied.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && !out_free |=> s1_valid)
    else $error("pending result dropped from read stage");

endmodule

`default_nettype wire

// ===== sv/bbx_cell.sv =====
// One window cell of the 3x3 boundary extractor: holds a single window column
// and hands it to its neighbor on every shift. Depends on bbx_pkg.
`default_nettype none

module bbx_cell
  import bbx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic clear,
  input  wire col_t col_in,
  output col_t      col
);

  // Clear wins over shift so that a frame restart empties the window.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bbx_line.sv =====
// Line store of the 3x3 boundary extractor: one word per image column with the
// flag of the row two above and the pixel of the row above. Depends on bbx_pkg.
`default_nettype none

module bbx_line
  import bbx_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output line_word_t             rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire line_word_t        wr_data
);

  line_word_t mem [DEPTH];

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_binary_boundary_3x3_core.sv =====
// Self-checking testbench for binary_boundary_3x3_core: raster frames go in, and every output
// beat is compared with a behavioral boundary predictor kept inside this module.
// Depends on bbx_pkg and the RTL of the block; needs no files or arguments.
module tb_binary_boundary_3x3_core;
  import bbx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  // Stream command carried in tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Cycles to let the block settle after the last expected beat.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int LIMIT_NS      = 20_000_000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } out_beat_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_index_t           cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata;   // [7:0] pixel
  logic                 s_axis_tuser;   // [0] cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [PIX_W-1:0]     m_axis_tdata;   // [7:0] out_pixel
  logic                 m_axis_tlast;   // frame_end

  binary_boundary_3x3_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: registers, line stores, window and raster position.
  bit             mode_conn;
  bit             mode_ground;
  int             frame_w = 640;
  int             frame_h = 480;
  bit             line_flags [MAX_W];
  bit [PIX_W-1:0] line_pixels [MAX_W];
  bit [2:0]       win_up;
  bit [23:0]      win_mid;
  bit [2:0]       win_low;
  int             in_col;
  int             in_row;
  int             out_idx;

  // Output beats predicted but not yet seen.
  out_beat_t pending_pixels [$];

  bit idling;
  int mismatches;
  int beats_checked;
  int frames_closed;
  int reg_writes;
  int items_counted;
  int ignored_flushes;
  int rx_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_frame();
    win_up  = '0;
    win_mid = '0;
    win_low = '0;
    in_col  = 0;
    in_row  = 0;
    out_idx = 0;
  endfunction

  function automatic int clamp_size(input logic [SIZE_W-1:0] value, input int limit);
    int v;
    v = int'(value);
    if (v < 3) v = 3;
    if (v > limit) v = limit;
    return v;
  endfunction

  // Advances the boundary predictor by one accepted beat; returns 0 for a dropped flush.
  function automatic bit boundary_step(input logic cmd, input logic [PIX_W-1:0] pix_in);
    bit               drain;
    bit               up;
    bit               need;
    bit               hit;
    bit               last;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] center;
    int               col;
    int               total;
    out_beat_t        beat;
    drain = (in_row >= frame_h);
    if (cmd == CMD_FLUSH && !drain) return 1'b0;
    pix = drain ? '0 : pix_in;
    col = in_col;
    up  = line_flags[col];
    mid = line_pixels[col];
    line_flags[col]  = |mid;
    line_pixels[col] = pix;
    win_up  = {win_up[1:0], up};
    win_mid = {win_mid[15:0], mid};
    win_low = {win_low[1:0], |pix};
    if (in_row >= 2 || (in_row == 1 && col >= 1)) begin
      center = win_mid[15:8];
      // Only interior centers can be thinned.
      if (col >= 2 && in_row >= 2 && in_row <= frame_h - 1) begin
        need = !mode_ground;
        hit = ((|center) == need) && (win_up[1] == need) && (win_low[1] == need) &&
              ((|win_mid[23:16]) == need) && ((|win_mid[7:0]) == need);
        if (mode_conn) begin
          hit = hit && (win_up[0] == need) && (win_up[2] == need) &&
                (win_low[0] == need) && (win_low[2] == need);
        end
        if (hit) center = mode_ground ? FILL_PIXEL : CLEAR_PIXEL;
      end
      total = frame_w * frame_h;
      last = (out_idx == total - 1);
      beat.pixel = center;
      beat.frame_end = last;
      pending_pixels.push_back(beat);
      if (last) begin
        restart_frame();
        return 1'b1;
      end
      out_idx++;
    end
    in_col = col + 1;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row++;
    end
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    if (!idling) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(input int density);
    if ($urandom_range(0, 99) >= density) return '0;
    if ($urandom_range(0, 2) == 0) return 8'hFF;
    return PIX_W'($urandom_range(1, 255));
  endfunction

  // Sends one beat on the input stream and updates the predictor once it is taken.
  task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pix);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    if (boundary_step(cmd, pix)) items_counted++;
    else ignored_flushes++;
  endtask

  // Writes one register; cfg_valid stays high until close_cfg.
  task automatic write_cfg(input cfg_index_t idx, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_CONNECTIVITY: mode_conn = value[0];
      CFG_GROUND:       mode_ground = value[0];
      CFG_WIDTH: begin
        frame_w = clamp_size(value, MAX_W);
        restart_frame();
      end
      CFG_HEIGHT: begin
        frame_h = clamp_size(value, MAX_H);
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted beat has arrived and the pipeline has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modes_random();
    write_cfg(CFG_CONNECTIVITY, SIZE_W'($urandom_range(0, 2047)));
    write_cfg(CFG_GROUND, SIZE_W'($urandom_range(0, 2047)));
  endtask

  // Sends up to pixel_count pixels of a frame, with optional stray flushes and a mode
  // change at split_at; drains the frame when drain is set.
  task automatic run_frame(input int density, input int noise_pct, input int split_at,
                           input int pixel_count, input bit drain);
    int n;
    for (n = 0; n < pixel_count; n++) begin
      if (n == split_at) begin
        wait_idle();
        write_modes_random();
        close_cfg();
      end
      // A flush ahead of the last pixel is dropped by the block.
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
        send_beat(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
      send_beat(CMD_PIXEL, rand_pixel(density));
    end
    if (drain) begin
      // Drain beats are mostly flushes; a pixel beat here acts as a flush too.
      for (n = 0; n <= frame_w; n++) begin
        if ($urandom_range(0, 4) == 0) send_beat(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
        else send_beat(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Smallest frame, clamped sizes, eight-connected foreground thinning, a stray flush
  // and a pixel beat during drain.
  task automatic test_directed_foreground();
    logic [PIX_W-1:0] pix [9];
    int n;
    pix = '{8'hFF, 8'h01, 8'h80, 8'h40, 8'hFF, 8'h02, 8'hFF, 8'h04, 8'hFF};
    idling = 1'b0;
    write_cfg(CFG_WIDTH, 11'd0);
    write_cfg(CFG_HEIGHT, 11'd2);
    write_cfg(CFG_CONNECTIVITY, 11'd1);
    write_cfg(CFG_GROUND, 11'd0);
    close_cfg();
    for (n = 0; n < 9; n++) begin
      if (n == 4) send_beat(CMD_FLUSH, 8'h00);
      send_beat(CMD_PIXEL, pix[n]);
    end
    send_beat(CMD_FLUSH, 8'hFF);
    send_beat(CMD_PIXEL, 8'hAA);
    send_beat(CMD_FLUSH, 8'h00);
    send_beat(CMD_FLUSH, 8'h55);
    wait_idle();
  endtask

  // Background thinning with connectivity switched partway through the frame.
  task automatic test_directed_background();
    int n;
    idling = 1'b1;
    write_cfg(CFG_GROUND, 11'd1);
    write_cfg(CFG_CONNECTIVITY, 11'd0);
    close_cfg();
    for (n = 0; n < 5; n++) send_beat(CMD_PIXEL, 8'h00);
    wait_idle();
    write_cfg(CFG_CONNECTIVITY, 11'd1);
    close_cfg();
    for (n = 0; n < 4; n++) send_beat(CMD_PIXEL, 8'h00);
    for (n = 0; n < 4; n++) send_beat(CMD_FLUSH, 8'h00);
    wait_idle();
  endtask

  // Random small frames: mostly complete ones, some with stray flushes, some cut short.
  task automatic test_random_frames();
    int w;
    int h;
    int density;
    int kind;
    int total;
    int split_at;
    while (items_counted < RANDOM_ITEMS) begin
      idling = ($urandom_range(0, 4) != 0);
      write_modes_random();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 40) : $urandom_range(0, 8);
      h = $urandom_range(0, 6);
      write_cfg(CFG_WIDTH, SIZE_W'(w));
      write_cfg(CFG_HEIGHT, SIZE_W'(h));
      close_cfg();
      case ($urandom_range(0, 4))
        0: density = 100;
        1: density = 90;
        2: density = 50;
        3: density = 10;
        default: density = 0;
      endcase
      total = frame_w * frame_h;
      split_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total - 1) : -1;
      kind = $urandom_range(0, 9);
      if (kind == 0) run_frame(density, 0, -1, $urandom_range(1, total - 1), 1'b0);
      else if (kind == 1) run_frame(density, 15, split_at, total, 1'b1);
      else run_frame(density, 0, split_at, total, 1'b1);
      wait_idle();
    end
  endtask

  // Widest and tallest frames, both reached through clamping; each is cut short after
  // its first rows so the column store is used end to end without a full frame.
  task automatic test_extreme_sizes();
    idling = 1'b1;
    write_cfg(CFG_WIDTH, 11'd2047);
    write_cfg(CFG_HEIGHT, 11'd3);
    write_cfg(CFG_CONNECTIVITY, 11'd0);
    write_cfg(CFG_GROUND, 11'd0);
    close_cfg();
    run_frame(80, 0, -1, frame_w + 24, 1'b0);
    wait_idle();
    idling = 1'b0;
    write_cfg(CFG_WIDTH, 11'd3);
    write_cfg(CFG_HEIGHT, 11'd2047);
    write_cfg(CFG_CONNECTIVITY, 11'd1);
    write_cfg(CFG_GROUND, 11'd1);
    close_cfg();
    run_frame(20, 0, -1, 48, 1'b0);
    wait_idle();
  endtask

  // Output side: random back-pressure drawn after every beat.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_gap = draw_gap();
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compares every output beat with the oldest predicted one.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (m_axis_tlast === 1'b1) frames_closed++;
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected beat pixel %02h last %0b", $realtime, m_axis_tdata,
                   m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.frame_end) begin
          if (mismatches < 10)
            $display("%0t: mismatch: expected pixel %02h last %0b, got pixel %02h last %0b",
                     $realtime, want.pixel, want.frame_end, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_CONNECTIVITY;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PIXEL;
    idling        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_foreground();
    test_directed_background();
    test_extreme_sizes();
    test_random_frames();
    wait_idle();
    if (pending_pixels.size() != 0) mismatches += pending_pixels.size();
    $display("Covered %0d pixel and drain beats, %0d dropped flushes, %0d register writes.",
             items_counted, ignored_flushes, reg_writes);
    $display("Checked %0d output beats over %0d completed frames, %0d mismatches.",
             beats_checked, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a stalled stream.
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d beats still expected.", pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bbx_pkg.sv
sv/bbx_cell.sv
sv/bbx_line.sv
sv/binary_boundary_3x3_core.sv
sim/tb_binary_boundary_3x3_core.sv
